[sv/quoted_command_line_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// Quoted command line tokenizer: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef QUOTED_COMMAND_LINE_TOKENIZER_MACROS_SVH
`define QUOTED_COMMAND_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define QCLT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qclt: same-cycle check failed");

// next-cycle implication
`define QCLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qclt: next-cycle check failed");

`endif

[sv/qclt_pkg.sv]
// ----------------------------------------------------------------------------
// Quoted command line tokenizer: package
// Beat types, state and error codes, character constants and helpers.
// ----------------------------------------------------------------------------
package qclt_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_TOKEN = 2'd1,
      PH_SKIP  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      Q_NONE   = 2'd0,
      Q_SINGLE = 2'd1,
      Q_DOUBLE = 2'd2
   } quote_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_ESC_AT_END = 2'd1,
      ERR_BAD_ESC    = 2'd2,
      ERR_OPEN_QUOTE = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_last;
   } req_type;

   typedef struct packed {
      logic [7:0] tok_byte;
      logic       byte_valid;
      logic       token_done;
      logic [1:0] error_kind;
   } rsp_type;

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_quote_char(input logic [7:0] c);
      return (c == CH_SQUOTE) || (c == CH_DQUOTE);
   endfunction

   function automatic quote_type quote_kind(input logic [7:0] c);
      return (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
   endfunction

endpackage

[sv/quoted_command_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// Quoted command line tokenizer
// Shell-style word splitting of a byte stream into token bytes and marks.
// ----------------------------------------------------------------------------
// Takes one command line byte per beat and returns at most one result beat
// per byte through a registered output. A new byte is accepted every cycle
// while req_stall is low. The result register is backed by a one-beat skid
// stage, so req_stall rises only when the output has been stalled with a
// further result already pending.
// ----------------------------------------------------------------------------
`include "quoted_command_line_tokenizer_macros.svh"

module quoted_command_line_tokenizer import qclt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   phase_type phase_ff, phase_in;
   quote_type quote_ff, quote_in;
   logic      esc_ff, esc_in;
   logic      has_ff, has_in;

   rsp_type   out_ff, skid_ff, res;
   logic      out_valid_ff, skid_valid_ff;
   logic      res_valid;
   logic      accept;

   logic      emit, done, last;
   logic [7:0] c, byte_val;
   err_type   err;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      c        = req_data.in_byte;
      last     = req_data.line_last;
      phase_in = phase_ff;
      quote_in = quote_ff;
      esc_in   = esc_ff;
      has_in   = has_ff;
      emit     = 1'b0;
      done     = 1'b0;
      byte_val = 8'h00;
      err      = ERR_NONE;
      res      = '0;
      res_valid = 1'b0;

      unique case (phase_ff)
         PH_IDLE, PH_TOKEN: begin
            priority if (esc_ff) begin
               esc_in = 1'b0;
               if (c == CH_N) begin
                  byte_val = CH_NEWLINE;
                  emit     = 1'b1;
               end else if (is_quote_char(c) || is_sep(c) || c == CH_BACKSLASH) begin
                  byte_val = c;
                  emit     = 1'b1;
               end else begin
                  err = ERR_BAD_ESC;
               end
               if (emit) begin
                  has_in   = 1'b1;
                  phase_in = PH_TOKEN;
               end
            end else if (c == CH_BACKSLASH) begin
               esc_in   = 1'b1;
               phase_in = PH_TOKEN;
               if (last) err = ERR_ESC_AT_END;
            end else if (is_sep(c)) begin
               if (quote_ff != Q_NONE) begin
                  byte_val = c;
                  emit     = 1'b1;
                  has_in   = 1'b1;
               end else if (phase_ff == PH_TOKEN) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
                  has_in   = 1'b0;
               end
            end else if (is_quote_char(c)) begin
               if (quote_ff == Q_NONE) begin
                  quote_in = quote_kind(c);
                  phase_in = PH_TOKEN;
               end else if (quote_ff == quote_kind(c)) begin
                  quote_in = Q_NONE;
               end else begin
                  byte_val = c;
                  emit     = 1'b1;
                  has_in   = 1'b1;
               end
            end else begin
               byte_val = c;
               emit     = 1'b1;
               has_in   = 1'b1;
               phase_in = PH_TOKEN;
            end

            if (last && err == ERR_NONE) begin
               if (quote_in != Q_NONE) err = ERR_OPEN_QUOTE;
               else if (phase_in == PH_TOKEN && has_in) done = 1'b1;
            end

            if (err != ERR_NONE) begin
               phase_in       = last ? PH_IDLE : PH_SKIP;
               quote_in       = Q_NONE;
               esc_in         = 1'b0;
               has_in         = 1'b0;
               res.error_kind = err;
               res_valid      = 1'b1;
            end else begin
               if (last) begin
                  phase_in = PH_IDLE;
                  quote_in = Q_NONE;
                  esc_in   = 1'b0;
                  has_in   = 1'b0;
               end
               res.tok_byte   = emit ? byte_val : 8'h00;
               res.byte_valid = emit;
               res.token_done = done;
               res_valid      = emit || done;
            end
         end
         default: begin
            if (last) begin
               phase_in = PH_IDLE;
               quote_in = Q_NONE;
               esc_in   = 1'b0;
               has_in   = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         quote_ff <= Q_NONE;
         esc_ff   <= 1'b0;
         has_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         quote_ff <= quote_in;
         esc_ff   <= esc_in;
         has_ff   <= has_in;
      end
   end

   // output register with one-beat skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_ff  <= skid_valid_ff || (accept && res_valid);
         skid_valid_ff <= 1'b0;
      end else if (accept && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept && res_valid) begin
         skid_ff <= res;
      end
   end

   `QCLT_ASSERT_SAME(a_skid_implies_out, clock, reset, skid_valid_ff, out_valid_ff)
   `QCLT_ASSERT_SAME(a_err_beat_clean, clock, reset,
      out_valid_ff && out_ff.error_kind != ERR_NONE,
      !out_ff.byte_valid && !out_ff.token_done && out_ff.tok_byte == 8'h00)
   `QCLT_ASSERT_SAME(a_byte_zero_when_unused, clock, reset,
      out_valid_ff && !out_ff.byte_valid, out_ff.tok_byte == 8'h00)
   `QCLT_ASSERT_NEXT(a_line_end_clears, clock, reset, accept && req_data.line_last,
      phase_ff == PH_IDLE && quote_ff == Q_NONE && !esc_ff && !has_ff)
   `QCLT_ASSERT_SAME(a_skip_is_clean, clock, reset, phase_ff == PH_SKIP,
      quote_ff == Q_NONE && !esc_ff && !has_ff)

endmodule

[test/quoted_command_line_tokenizer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quoted command line tokenizer testbench
// Feeds whole command lines byte by byte. The lines are a short directed set
// plus random lines: well-formed, broken and noise. A local word splitter
// predicts every token byte, token end and error beat. Both sides idle and
// stall at random. One long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module quoted_command_line_tokenizer_tb;
   import qclt_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   quoted_command_line_tokenizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // stimulus and expectations
   req_type    line_bytes_q[$];
   rsp_type    pending_token_beats[$];
   logic [7:0] line_buf[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked = 0;
   int n_queued = 0;
   int n_lines = 0;
   int n_bytes_in = 0;
   int n_beats_out = 0;
   int n_tokens = 0;
   int n_errors = 0;
   int n_fail = 0;
   int quiet_cycles = 0;

   // splitter state
   phase_type tk_phase;
   quote_type tk_quote;
   logic      tk_escape;
   logic      tk_content;

   function automatic void restart_line();
      tk_phase   = PH_IDLE;
      tk_quote   = Q_NONE;
      tk_escape  = 1'b0;
      tk_content = 1'b0;
   endfunction

   function automatic void advance_tokenizer(input req_type beat);
      logic [7:0] c;
      logic       last, emit, done, sep, quo;
      logic [7:0] ch;
      err_type    err;
      quote_type  kind;
      rsp_type    r;
      c    = beat.in_byte;
      last = beat.line_last;
      emit = 1'b0;
      done = 1'b0;
      ch   = 8'h00;
      err  = ERR_NONE;
      sep  = (c == CH_SPACE) || (c == CH_TAB);
      quo  = (c == CH_SQUOTE) || (c == CH_DQUOTE);
      kind = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;

      if (tk_phase != PH_IDLE && tk_phase != PH_TOKEN) begin
         if (last) restart_line();
         return;
      end

      if (tk_escape) begin
         tk_escape = 1'b0;
         if (c == CH_N) begin
            ch   = CH_NEWLINE;
            emit = 1'b1;
         end else if (quo || sep || c == CH_BACKSLASH) begin
            ch   = c;
            emit = 1'b1;
         end else begin
            err = ERR_BAD_ESC;
         end
         if (emit) begin
            tk_content = 1'b1;
            tk_phase   = PH_TOKEN;
         end
      end else if (c == CH_BACKSLASH) begin
         tk_escape = 1'b1;
         tk_phase  = PH_TOKEN;
         if (last) err = ERR_ESC_AT_END;
      end else if (sep) begin
         if (tk_quote != Q_NONE) begin
            ch         = c;
            emit       = 1'b1;
            tk_content = 1'b1;
         end else if (tk_phase == PH_TOKEN) begin
            done       = 1'b1;
            tk_phase   = PH_IDLE;
            tk_content = 1'b0;
         end
      end else if (quo) begin
         if (tk_quote == Q_NONE) begin
            tk_quote = kind;
            tk_phase = PH_TOKEN;
         end else if (tk_quote == kind) begin
            tk_quote = Q_NONE;
         end else begin
            ch         = c;
            emit       = 1'b1;
            tk_content = 1'b1;
         end
      end else begin
         ch         = c;
         emit       = 1'b1;
         tk_content = 1'b1;
         tk_phase   = PH_TOKEN;
      end

      if (last && err == ERR_NONE) begin
         if (tk_quote != Q_NONE) err = ERR_OPEN_QUOTE;
         else if (tk_phase == PH_TOKEN && tk_content) done = 1'b1;
      end

      if (err != ERR_NONE) begin
         restart_line();
         if (!last) tk_phase = PH_SKIP;
         r = '0;
         r.error_kind = err;
         pending_token_beats.insert(pending_token_beats.size(), r);
         return;
      end

      if (last) restart_line();
      if (emit || done) begin
         r.tok_byte   = emit ? ch : 8'h00;
         r.byte_valid = emit;
         r.token_done = done;
         r.error_kind = ERR_NONE;
         pending_token_beats.insert(pending_token_beats.size(), r);
      end
   endfunction

   // line generation
   function automatic void add_char(input logic [7:0] c);
      line_buf.insert(line_buf.size(), c);
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE ||
             c == CH_BACKSLASH);
      return c;
   endfunction

   function automatic logic [7:0] sep_char();
      return $urandom_range(1) ? CH_SPACE : CH_TAB;
   endfunction

   function automatic logic [7:0] esc_target();
      case ($urandom_range(5))
         0: return CH_N;
         1: return CH_SPACE;
         2: return CH_TAB;
         3: return CH_SQUOTE;
         4: return CH_DQUOTE;
         default: return CH_BACKSLASH;
      endcase
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(7))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_SQUOTE;
         3: return CH_DQUOTE;
         4: return CH_BACKSLASH;
         5: return CH_N;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void add_group(input bit closed);
      logic [7:0] q, other;
      int n;
      q     = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      other = (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
      n     = $urandom_range(0, 3);
      add_char(q);
      repeat (n) begin
         case ($urandom_range(3))
            0: add_char(sep_char());
            1: add_char(other);
            2: begin
               add_char(CH_BACKSLASH);
               add_char(esc_target());
            end
            default: add_char(plain_char());
         endcase
      end
      if (closed) add_char(q);
   endfunction

   function automatic void add_token();
      int pieces;
      pieces = $urandom_range(1, 3);
      repeat (pieces) begin
         case ($urandom_range(3))
            0: add_group(1'b1);
            1: begin
               add_char(CH_BACKSLASH);
               add_char(esc_target());
            end
            default: repeat ($urandom_range(1, 3)) add_char(plain_char());
         endcase
      end
   endfunction

   function automatic void flush_line();
      req_type beat;
      foreach (line_buf[i]) begin
         beat.in_byte   = line_buf[i];
         beat.line_last = (i == line_buf.size() - 1);
         line_bytes_q.insert(line_bytes_q.size(), beat);
      end
      n_queued += line_buf.size();
      n_lines++;
      line_buf.delete();
   endfunction

   function automatic void add_random_line();
      int pick, k;
      pick = $urandom_range(99);
      if (pick < 70) begin
         if ($urandom_range(3) == 0) add_char(sep_char());
         k = $urandom_range(1, 3);
         for (int t = 0; t < k; t++) begin
            if (t != 0) repeat ($urandom_range(1, 2)) add_char(sep_char());
            add_token();
         end
         if ($urandom_range(3) == 0) add_char(sep_char());
      end else if (pick < 85) begin
         if ($urandom_range(1)) begin
            add_token();
            add_char(sep_char());
         end
         case ($urandom_range(2))
            0: add_char(CH_BACKSLASH);
            1: begin
               add_char(CH_BACKSLASH);
               add_char(plain_char());
            end
            default: add_group(1'b0);
         endcase
         k = $urandom_range(3);
         repeat (k) add_char(noise_char());
      end else begin
         k = $urandom_range(1, 8);
         repeat (k) add_char(noise_char());
      end
      flush_line();
   endfunction

   task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                            input bit with_hold);
      int goal;
      @(posedge clock);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
      goal = n_queued + n_items;
      while (n_queued < goal) add_random_line();
      if (with_hold) begin
         repeat (20) @(posedge clock);
         hold_asked <= hold_asked + 1;
      end
      while (line_bytes_q.size() != 0 || req_valid) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_tokenizer(req_data);
            n_bytes_in++;
         end
         if (!req_valid || !req_stall) begin
            if (line_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= line_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         n_fail++;
      end
   endfunction

   int hold_served = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_beats_out++;
            if (rsp_data.token_done) n_tokens++;
            if (rsp_data.error_kind != ERR_NONE) n_errors++;
            if (pending_token_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
               n_fail++;
            end else begin
               want = pending_token_beats.pop_front();
               check_field("tok_byte", want.tok_byte, rsp_data.tok_byte);
               check_field("byte_valid", want.byte_valid, rsp_data.byte_valid);
               check_field("token_done", want.token_done, rsp_data.token_done);
               check_field("error_kind", want.error_kind, rsp_data.error_kind);
            end
         end
         if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("quoted_command_line_tokenizer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      restart_line();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      line_buf = '{CH_SQUOTE, CH_SQUOTE, CH_SPACE, 8'h00, CH_TAB, 8'hFF};
      flush_line();
      line_buf = '{CH_TAB, CH_SPACE};
      flush_line();
      line_buf = '{CH_DQUOTE, CH_DQUOTE};
      flush_line();
      line_buf = '{CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_BACKSLASH, CH_BACKSLASH, CH_SQUOTE};
      flush_line();
      line_buf = '{CH_BACKSLASH};
      flush_line();
      line_buf = '{CH_BACKSLASH, 8'h78, 8'h7A};
      flush_line();
      line_buf = '{CH_SQUOTE, 8'h61};
      flush_line();
      line_buf = '{CH_DQUOTE, CH_SQUOTE, CH_TAB, CH_DQUOTE};
      flush_line();

      run_phase(13, 64, 230, 1'b0);
      run_phase(64, 13, 230, 1'b0);
      run_phase(0, 0, 240, 1'b1);

      while (pending_token_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d lines, %0d bytes in, %0d beats out", n_lines, n_bytes_in, n_beats_out);
      $display("%0d tokens closed, %0d error beats, %0d mismatches",
               n_tokens, n_errors, n_fail);
      if (n_fail == 0) begin
         $display("quoted_command_line_tokenizer verification clean");
      end else begin
         $display("quoted_command_line_tokenizer verification failed");
      end
      $finish;
   end

endmodule

[quoted_command_line_tokenizer.f]
+incdir+sv
sv/qclt_pkg.sv
sv/quoted_command_line_tokenizer.sv
test/quoted_command_line_tokenizer_tb.sv
